FILE: sv/qbc_pkg.sv
// Shared types and constants for the quoted bracket balance checker.
// No dependencies; imported by the front, back and top-level modules.
package qbc_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned QueueDepth        = 4;

  // Code units that carry meaning.
  localparam logic [15:0] CuDquote    = 16'h0022;
  localparam logic [15:0] CuSquote    = 16'h0027;
  localparam logic [15:0] CuSemicolon = 16'h003B;
  localparam logic [15:0] CuOpenParen = 16'h0028;
  localparam logic [15:0] CuOpenBrack = 16'h005B;
  localparam logic [15:0] CuOpenBrace = 16'h007B;
  localparam logic [15:0] CuShutParen = 16'h0029;
  localparam logic [15:0] CuShutBrack = 16'h005D;
  localparam logic [15:0] CuShutBrace = 16'h007D;
  localparam logic [15:0] CuBackslash = 16'h005C;

  typedef enum logic [2:0] {
    VERDICT_OK          = 3'd0,
    VERDICT_UNMATCHED   = 3'd1,
    VERDICT_MISMATCH    = 3'd2,
    VERDICT_SEMICOLON   = 3'd3,
    VERDICT_OPEN_QUOTE  = 3'd4,
    VERDICT_UNCLOSED    = 3'd5,
    VERDICT_OVERFLOW    = 3'd6
  } verdict_e;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_DQUOTE,
    CLS_SQUOTE,
    CLS_BSLASH,
    CLS_SEMI
  } unit_class_e;

  typedef enum logic [1:0] {
    KIND_PAREN = 2'd0,
    KIND_BRACK = 2'd1,
    KIND_BRACE = 2'd2
  } bracket_kind_e;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic       balanced;
    logic [2:0] verdict;
  } out_item_t;

  // One classified unit as it travels from the front to the back.
  typedef struct packed {
    unit_class_e   cls;
    bracket_kind_e kind;
    logic          last;
  } cls_item_t;

endpackage

FILE: sv/qbc_front.sv
// Front end: classifies incoming code units and holds them in a short queue.
// Depends on qbc_pkg.
module qbc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  qbc_pkg::in_item_t in_item_i,
  output logic              q_valid_o,
  output qbc_pkg::cls_item_t q_item_o,
  input  logic              q_pop_i
);
  import qbc_pkg::*;

  localparam int unsigned QAW = $clog2(QueueDepth);
  localparam int unsigned QCW = $clog2(QueueDepth + 1);

  cls_item_t          entry_q [QueueDepth];
  logic [QAW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]     fill_q, fill_d;
  logic               wr_en;
  cls_item_t          cls_item;

  function automatic cls_item_t classify(input in_item_t it);
    cls_item_t r;
    r.cls  = CLS_OTHER;
    r.kind = KIND_PAREN;
    r.last = it.last_unit;
    case (it.code_unit)
      CuDquote:    r.cls = CLS_DQUOTE;
      CuSquote:    r.cls = CLS_SQUOTE;
      CuSemicolon: r.cls = CLS_SEMI;
      CuBackslash: r.cls = CLS_BSLASH;
      CuOpenParen: begin r.cls = CLS_OPEN;  r.kind = KIND_PAREN; end
      CuOpenBrack: begin r.cls = CLS_OPEN;  r.kind = KIND_BRACK; end
      CuOpenBrace: begin r.cls = CLS_OPEN;  r.kind = KIND_BRACE; end
      CuShutParen: begin r.cls = CLS_CLOSE; r.kind = KIND_PAREN; end
      CuShutBrack: begin r.cls = CLS_CLOSE; r.kind = KIND_BRACK; end
      CuShutBrace: begin r.cls = CLS_CLOSE; r.kind = KIND_BRACE; end
      default:     r.cls = CLS_OTHER;
    endcase
    return r;
  endfunction

  assign cls_item  = classify(in_item_i);
  assign full      = (fill_q == QCW'(QueueDepth));
  assign wr_en     = push && !full;
  assign q_valid_o = (fill_q != '0);
  assign q_item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en   ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + QCW'(wr_en) - QCW'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

FILE: sv/qbc_back.sv
// Back end: quote tracking, bracket stack and verdict register.
// Depends on qbc_pkg; fed by qbc_front through its queue.
module qbc_back #(
  parameter int unsigned STACK_DEPTH = qbc_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  qbc_pkg::cls_item_t q_item_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output qbc_pkg::out_item_t out_item_o
);
  import qbc_pkg::*;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_e;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  bracket_kind_e stack_mem [STACK_DEPTH];
  bracket_kind_e below_q;            // stack entry under the top
  bracket_kind_e top_q, top_d;
  logic [CW-1:0] count_q, count_d;
  quote_e        quote_q, quote_d;
  logic          esc_q, esc_d;
  verdict_e      fail_q, fail_d;
  logic          out_valid_q;
  out_item_t     out_q;
  verdict_e      verdict;
  logic          out_ready;
  logic          push_en;
  logic [AW-1:0] rd_addr;

  assign out_ready = !out_valid_q || pop;
  assign q_pop_o   = q_valid_i && (!q_item_i.last || out_ready);

  always_comb begin
    top_d   = top_q;
    count_d = count_q;
    quote_d = quote_q;
    esc_d   = esc_q;
    fail_d  = fail_q;
    push_en = 1'b0;
    verdict = VERDICT_OK;
    if (q_pop_o) begin
      if (fail_q != VERDICT_OK) begin
        // hold the first failure, drop the unit
      end else if (quote_q != QUOTE_NONE) begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (q_item_i.cls == CLS_BSLASH) begin
          esc_d = 1'b1;
        end else if ((q_item_i.cls == CLS_DQUOTE && quote_q == QUOTE_DOUBLE) ||
                     (q_item_i.cls == CLS_SQUOTE && quote_q == QUOTE_SINGLE)) begin
          quote_d = QUOTE_NONE;
        end
      end else begin
        unique case (q_item_i.cls)
          CLS_DQUOTE: quote_d = QUOTE_DOUBLE;
          CLS_SQUOTE: quote_d = QUOTE_SINGLE;
          CLS_SEMI:   fail_d  = VERDICT_SEMICOLON;
          CLS_OPEN: begin
            if (count_q == CW'(STACK_DEPTH)) begin
              fail_d = VERDICT_OVERFLOW;
            end else begin
              push_en = 1'b1;
              top_d   = q_item_i.kind;
              count_d = count_q + 1'b1;
            end
          end
          CLS_CLOSE: begin
            if (count_q == '0) begin
              fail_d = VERDICT_UNMATCHED;
            end else if (top_q != q_item_i.kind) begin
              fail_d = VERDICT_MISMATCH;
            end else begin
              top_d   = below_q;
              count_d = count_q - 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (q_item_i.last) begin
        if (fail_d != VERDICT_OK) begin
          verdict = fail_d;
        end else if (quote_d != QUOTE_NONE) begin
          verdict = VERDICT_OPEN_QUOTE;
        end else if (count_d != '0) begin
          verdict = VERDICT_UNCLOSED;
        end else begin
          verdict = VERDICT_OK;
        end
        count_d = '0;
        quote_d = QUOTE_NONE;
        esc_d   = 1'b0;
        fail_d  = VERDICT_OK;
      end
    end
  end

  // Prefetch the entry below the next top so a pop can take its new top from below_q.
  assign rd_addr = AW'(count_d - CW'(2));

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[count_q[AW-1:0]] <= q_item_i.kind;
    end
    below_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      quote_q     <= QUOTE_NONE;
      esc_q       <= 1'b0;
      fail_q      <= VERDICT_OK;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      quote_q <= quote_d;
      esc_q   <= esc_d;
      fail_q  <= fail_d;
      if (q_pop_o && q_item_i.last) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (q_pop_o && q_item_i.last) begin
      out_q.balanced <= (verdict == VERDICT_OK);
      out_q.verdict  <= verdict;
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

endmodule

FILE: sv/quoted_bracket_balance_checker.sv
// Quoted bracket balance checker: one code unit per cycle unless full, one verdict per string.
// The last unit passes through the queue and then the verdict register before its result is
// on the ports; units still queued ahead of it are handled first.
// The back end takes one queued unit per cycle; a last unit waits until the prior verdict is popped.
// Reset clears the queue, quote, escape, failure and count state; the stack memory
// is not cleared and needs no clearing pass, since only entries of the current string are read.
module quoted_bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = qbc_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  qbc_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output qbc_pkg::out_item_t out_item_o
);
  import qbc_pkg::*;

  // Classified units between the front and back.
  logic      q_valid;
  logic      q_pop;
  cls_item_t q_item;

  // Front: classify each unit and hold it in the queue so the input side
  // keeps streaming while the back waits on a full result register.
  qbc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // Back: advance quote and stack state per unit; on the last unit load the
  // verdict register and clear the string state. Non-last units advance even
  // while a verdict waits to be taken.
  qbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // The back never drains a queue slot that holds no transaction.
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back popped an empty queue");

  // An accepted transaction is visible to the back on the next cycle.
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> q_valid)
    else $error("accepted transaction not queued");

  // The balanced flag agrees with the verdict code.
  a_flag_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.balanced == (out_item_o.verdict == VERDICT_OK)))
    else $error("balanced flag disagrees with verdict");

endmodule
